### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. They compile to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define QTE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define QTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QTE_ASSERT(lbl, clk, rst, prop, msg)
`define QTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Constants shared by the quaternion to Euler angle datapath.
// ----------------------------------------------------------------------------
package qte_pkg;

  // CORDIC datapath widths.
  localparam int XY_W     = 34;
  localparam int ACC_W    = 34;
  localparam int ANG_W    = ACC_W - 16;
  localparam int NORM_MSB = 29;

  // Square root datapath: radicand below 2^61, one result bit per stage.
  localparam int SQ_W       = 62;
  localparam int SQRT_STEPS = 31;
  localparam int S30_W      = 32;

  // Angles with 2^31 standing for pi.
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ACC_W-1:0] ROUND_HALF   = 34'sd32768;

  // atan(2^-i) per CORDIC step.
  localparam logic signed [ACC_W-1:0] ATAN_TAB [32] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10680862,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81,
    34'sd41,        34'sd20,        34'sd10,        34'sd5,
    34'sd3,         34'sd1,         34'sd1,         34'sd0
  };

endpackage

### rtl/qte_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_stream_if
// Valid/ready channels: quaternion in, Euler angles out.
// ----------------------------------------------------------------------------
interface qte_quat_if #(
  parameter int COMP_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] comp_w;
  logic signed [COMP_WIDTH-1:0] comp_x;
  logic signed [COMP_WIDTH-1:0] comp_y;
  logic signed [COMP_WIDTH-1:0] comp_z;

  modport source (output valid, comp_w, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

### rtl/qte_atan2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined atan2(y, x): operand normalization, quarter turn pre-rotation and
// one vectoring CORDIC step per stage, then a registered rounded output.
// ----------------------------------------------------------------------------
module qte_atan2 #(
  parameter int IN_W  = 32,
  parameter int ITERS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [IN_W-1:0]            y_in,
  input  logic signed [IN_W-1:0]            x_in,
  output logic                              out_valid,
  output logic signed [qte_pkg::ANG_W-1:0]  ang
);
  import qte_pkg::*;

  localparam int POS_W = $clog2(IN_W);
  localparam int EW    = IN_W + NORM_MSB + 1;

  // Stage A: magnitudes merged for the leading one search.
  logic                   a_vld, a_zero;
  logic signed [IN_W-1:0] a_x, a_y;
  logic [IN_W-1:0]        a_or, ax, ay;

  always_comb begin
    ax = x_in[IN_W-1] ? IN_W'(-x_in) : IN_W'(x_in);
    ay = y_in[IN_W-1] ? IN_W'(-y_in) : IN_W'(y_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x    <= x_in;
      a_y    <= y_in;
      a_or   <= ax | ay;
      a_zero <= (x_in == '0) && (y_in == '0);
    end
  end

  // Stage B: position of the leading one of the larger magnitude.
  logic                   b_vld, b_zero;
  logic signed [IN_W-1:0] b_x, b_y;
  logic [POS_W-1:0]       b_pos, b_pos_next;

  always_comb begin
    b_pos_next = '0;
    for (int j = 0; j < IN_W; j++) begin
      if (a_or[j]) begin
        b_pos_next = POS_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x    <= a_x;
      b_y    <= a_y;
      b_pos  <= b_pos_next;
      b_zero <= a_zero;
    end
  end

  // Stage C: scale so the larger magnitude lies in [2^29, 2^30).
  logic                   c_vld, c_zero;
  logic signed [XY_W-1:0] c_x, c_y;
  logic signed [EW-1:0]   xe, ye, xs, ys;

  always_comb begin
    xe = {{(NORM_MSB + 1){b_x[IN_W-1]}}, b_x};
    ye = {{(NORM_MSB + 1){b_y[IN_W-1]}}, b_y};
    if (int'(b_pos) >= NORM_MSB) begin
      xs = xe >>> (int'(b_pos) - NORM_MSB);
      ys = ye >>> (int'(b_pos) - NORM_MSB);
    end else begin
      xs = xe <<< (NORM_MSB - int'(b_pos));
      ys = ye <<< (NORM_MSB - int'(b_pos));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x    <= XY_W'(xs);
      c_y    <= XY_W'(ys);
      c_zero <= b_zero;
    end
  end

  // Stage D: quarter turn pre-rotation brings x to the right half plane.
  logic signed [XY_W-1:0]  cx  [0:ITERS];
  logic signed [XY_W-1:0]  cy  [0:ITERS];
  logic signed [ACC_W-1:0] ca  [0:ITERS];
  logic                    cz  [0:ITERS];
  logic                    cv  [0:ITERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cz[0] <= c_zero;
      if (c_x < 0) begin
        if (c_y >= 0) begin
          cx[0] <= c_y;
          cy[0] <= -c_x;
          ca[0] <= QUARTER_TURN;
        end else begin
          cx[0] <= -c_y;
          cy[0] <= c_x;
          ca[0] <= -QUARTER_TURN;
        end
      end else begin
        cx[0] <= c_x;
        cy[0] <= c_y;
        ca[0] <= '0;
      end
    end
  end

  // CORDIC steps; y equal to zero rotates as if negative.
  for (genvar i = 0; i < ITERS; i++) begin : g_step
    logic signed [XY_W-1:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cz[i+1] <= cz[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          ca[i+1] <= ca[i] + ATAN_TAB[i];
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          ca[i+1] <= ca[i] - ATAN_TAB[i];
        end
      end
    end
  end

  // Output stage: round to the 16 bit binary angle scale.
  logic signed [ACC_W-1:0] rnd;
  assign rnd = ca[ITERS] + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= cz[ITERS] ? '0 : rnd[ACC_W-1:16];
    end
  end

  // Only the last CORDIC x and y are not consumed.
  logic unused_tail;
  assign unused_tail = ^{cx[ITERS], cy[ITERS]};

endmodule

### rtl/quaternion_to_euler_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Quaternion (Q2.14) to roll, pitch and yaw binary angles, fully pipelined.
//
//   Channel  Direction  Payload
//   quat     in         comp_w, comp_x, comp_y, comp_z
//   euler    out        roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One item is taken per cycle unless a result waits unaccepted on euler. The
// path runs through four product and sum stages, 31 square root stages for
// the pitch cosine, the CORDIC pipeline and the output register.
// Reset clears only the valid bits. A stall on euler freezes every stage at
// once; quat.ready falls only while the output register holds a waiting item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_euler_angles_top #(
  parameter int COMP_WIDTH   = 16,
  parameter int CORDIC_ITERS = 16
) (
  input logic        clk,
  input logic        rst,
  qte_quat_if.sink   quat,
  qte_euler_if.source euler
);
  import qte_pkg::*;

  localparam int MR_W      = 2 * COMP_WIDTH - 2;
  localparam int WW        = 2 * COMP_WIDTH + 2;
  localparam int WORK_FRAC = 2 * COMP_WIDTH - 6;
  localparam int SHIFT_D   = WORK_FRAC - 30;
  localparam int SHW       = WW + 21;
  localparam int DLY       = 2 + SQRT_STEPS;
  localparam int ATAN_LAT  = CORDIC_ITERS + 5;

  localparam int P_WX = 0, P_YZ = 1, P_XX = 2, P_YY = 3, P_WZ = 4;
  localparam int P_XY = 5, P_ZZ = 6, P_ZX = 7, P_WY = 8, NPROD = 9;

  localparam logic signed [WW-1:0] ONE   = WW'(1) <<< WORK_FRAC;
  localparam logic [SQ_W-1:0]      ONE60 = SQ_W'(1) << 60;

  // Global advance: every stage moves unless a result waits at the output.
  logic out_vld, adv;
  assign adv        = !out_vld || euler.ready;
  assign quat.ready = adv;

  // Stage 1: the nine component products, each floored by a factor of four.
  logic signed [COMP_WIDTH-1:0]   op_a [NPROD];
  logic signed [COMP_WIDTH-1:0]   op_b [NPROD];
  logic signed [MR_W-1:0]         p1   [NPROD];
  logic                           v1;

  always_comb begin
    op_a[P_WX] = quat.comp_w; op_b[P_WX] = quat.comp_x;
    op_a[P_YZ] = quat.comp_y; op_b[P_YZ] = quat.comp_z;
    op_a[P_XX] = quat.comp_x; op_b[P_XX] = quat.comp_x;
    op_a[P_YY] = quat.comp_y; op_b[P_YY] = quat.comp_y;
    op_a[P_WZ] = quat.comp_w; op_b[P_WZ] = quat.comp_z;
    op_a[P_XY] = quat.comp_x; op_b[P_XY] = quat.comp_y;
    op_a[P_ZZ] = quat.comp_z; op_b[P_ZZ] = quat.comp_z;
    op_a[P_ZX] = quat.comp_z; op_b[P_ZX] = quat.comp_x;
    op_a[P_WY] = quat.comp_w; op_b[P_WY] = quat.comp_y;
  end

  for (genvar k = 0; k < NPROD; k++) begin : g_prod
    logic signed [2*COMP_WIDTH-1:0] prod;
    assign prod = op_a[k] * op_b[k];
    always_ff @(posedge clk) begin
      if (adv) begin
        p1[k] <= MR_W'(prod >>> 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= quat.valid;
    end
  end

  // Stage 2: atan2 operands, clamped asin argument rescaled to 30 fraction bits.
  logic signed [WW-1:0]    ry, rx, yy, yx, s_raw, s_cl;
  logic signed [SHW-1:0]   s_ext, s_shift;
  logic                    s_flag;
  logic signed [WW-1:0]    s2_ry, s2_rx, s2_yy, s2_yx;
  logic signed [S30_W-1:0] s2_s30;
  logic                    s2_flag, v2;

  always_comb begin
    ry    = (WW'(p1[P_WX]) + WW'(p1[P_YZ])) <<< 1;
    rx    = ONE - ((WW'(p1[P_XX]) + WW'(p1[P_YY])) <<< 1);
    yy    = (WW'(p1[P_WZ]) + WW'(p1[P_XY])) <<< 1;
    yx    = ONE - ((WW'(p1[P_YY]) + WW'(p1[P_ZZ])) <<< 1);
    s_raw = (WW'(p1[P_ZX]) - WW'(p1[P_WY])) <<< 1;
    if (s_raw > ONE) begin
      s_cl   = ONE;
      s_flag = 1'b1;
    end else if (s_raw < -ONE) begin
      s_cl   = -ONE;
      s_flag = 1'b1;
    end else begin
      s_cl   = s_raw;
      s_flag = 1'b0;
    end
    s_ext = SHW'(s_cl);
  end

  if (SHIFT_D >= 0) begin : g_s30_down
    assign s_shift = s_ext >>> SHIFT_D;
  end else begin : g_s30_up
    assign s_shift = s_ext <<< (-SHIFT_D);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ry   <= ry;
      s2_rx   <= rx;
      s2_yy   <= yy;
      s2_yx   <= yx;
      s2_s30  <= S30_W'(s_shift);
      s2_flag <= s_flag;
    end
  end

  // Stage 3: square of the asin argument.
  logic signed [2*S30_W-1:0] sq_full;
  logic [SQ_W-1:0]           s3_sq;
  logic signed [S30_W-1:0]   s3_s30;
  logic                      s3_flag, v3;

  assign sq_full = s2_s30 * s2_s30;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sq   <= sq_full[SQ_W-1:0];
      s3_s30  <= s2_s30;
      s3_flag <= s2_flag;
    end
  end

  // Stage 4 and the square root stages: cosine = floor(sqrt(2^60 - s*s)),
  // one result bit per stage.
  logic [SQ_W-1:0]         sv   [0:SQRT_STEPS];
  logic [SQ_W-1:0]         sr   [0:SQRT_STEPS];
  logic signed [S30_W-1:0] ps30 [0:SQRT_STEPS];
  logic                    pfl  [0:SQRT_STEPS];
  logic                    qv   [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (adv) begin
      qv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv[0]   <= ONE60 - s3_sq;
      sr[0]   <= '0;
      ps30[0] <= s3_s30;
      pfl[0]  <= s3_flag;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = sr[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else if (adv) begin
        qv[k+1] <= qv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ps30[k+1] <= ps30[k];
        pfl[k+1]  <= pfl[k];
        if (sv[k] >= trial) begin
          sv[k+1] <= sv[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
      end
    end
  end

  // Roll and yaw operands wait alongside the square root.
  logic signed [WW-1:0] d_ry [DLY];
  logic signed [WW-1:0] d_rx [DLY];
  logic signed [WW-1:0] d_yy [DLY];
  logic signed [WW-1:0] d_yx [DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ry[0] <= s2_ry;
      d_rx[0] <= s2_rx;
      d_yy[0] <= s2_yy;
      d_yx[0] <= s2_yx;
      for (int k = 1; k < DLY; k++) begin
        d_ry[k] <= d_ry[k-1];
        d_rx[k] <= d_rx[k-1];
        d_yy[k] <= d_yy[k-1];
        d_yx[k] <= d_yx[k-1];
      end
    end
  end

  // Three arctangent pipelines in lockstep.
  logic signed [ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;
  logic                    atan_vld, pitch_vld, yaw_vld;
  logic signed [S30_W-1:0] cos_val;

  assign cos_val = S30_W'(sr[SQRT_STEPS]);

  qte_atan2 #(.IN_W(WW), .ITERS(CORDIC_ITERS)) u_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (qv[SQRT_STEPS]),
    .y_in      (d_ry[DLY-1]),
    .x_in      (d_rx[DLY-1]),
    .out_valid (atan_vld),
    .ang       (roll_ang)
  );

  qte_atan2 #(.IN_W(S30_W), .ITERS(CORDIC_ITERS)) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (qv[SQRT_STEPS]),
    .y_in      (ps30[SQRT_STEPS]),
    .x_in      (cos_val),
    .out_valid (pitch_vld),
    .ang       (pitch_ang)
  );

  qte_atan2 #(.IN_W(WW), .ITERS(CORDIC_ITERS)) u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (qv[SQRT_STEPS]),
    .y_in      (d_yy[DLY-1]),
    .x_in      (d_yx[DLY-1]),
    .out_valid (yaw_vld),
    .ang       (yaw_ang)
  );

  // Clamp flag follows the arctangent latency.
  logic fd [ATAN_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      fd[0] <= pfl[SQRT_STEPS];
      for (int k = 1; k < ATAN_LAT; k++) begin
        fd[k] <= fd[k-1];
      end
    end
  end

  // Output register with pitch saturated to a quarter turn.
  logic signed [15:0] pitch_sat;
  logic signed [15:0] roll_q, pitch_q, yaw_q;
  logic               flag_q;

  always_comb begin
    if (pitch_ang > 18'sd16384) begin
      pitch_sat = 16'sd16384;
    end else if (pitch_ang < -18'sd16384) begin
      pitch_sat = -16'sd16384;
    end else begin
      pitch_sat = pitch_ang[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= atan_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_q  <= roll_ang[15:0];
      pitch_q <= pitch_sat;
      yaw_q   <= yaw_ang[15:0];
      flag_q  <= fd[ATAN_LAT-1];
    end
  end

  assign euler.valid         = out_vld;
  assign euler.roll_angle    = roll_q;
  assign euler.pitch_angle   = pitch_q;
  assign euler.yaw_angle     = yaw_q;
  assign euler.pitch_clamped = flag_q;

  // Assertions.
  `QTE_ASSERT(a_stall_only_on_backpressure, clk, rst, !quat.ready |-> (euler.valid && !euler.ready), "input stalled without output backpressure")
  `QTE_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !euler.valid, "result present right after reset")
  `QTE_ASSERT(a_pitch_in_range, clk, rst, euler.valid |-> (euler.pitch_angle <= 16'sd16384 && euler.pitch_angle >= -16'sd16384), "pitch beyond a quarter turn")
  `QTE_ASSERT(a_atan_lockstep, clk, rst, (pitch_vld == atan_vld) && (yaw_vld == atan_vld), "arctangent pipelines out of step")

endmodule
